[sv/swrs_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swrs_pkg
// Shared types and codes for the sliding window rank sorter.
// ---------------------------------------------------------------------------
package swrs_pkg;

   // request op codes
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_RANK = 2'd1;
   localparam logic [1:0] OP_AGE  = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned CSR_W    = 7;
   localparam logic [CSR_W-1:0] WINDOW_SIZE_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]                 op;
      logic signed [SAMPLE_W-1:0] sample;
      logic [POS_W-1:0]           position;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       bad_position;
   } rsp_type;

   // compare flags a cell shares with its neighbors
   typedef struct packed {
      logic lt_old;   // own key sorts before the evicted key
      logic lt_new;   // own key sorts before the incoming key
   } cell_flag_type;

endpackage

[sv/swrs_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swrs_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module swrs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/swrs_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swrs_cell
// One rank cell: holds the sample at its rank and the slot it came from.
// On an add, evicts the old key and inserts the new one using neighbor data.
// ---------------------------------------------------------------------------
module swrs_cell #(
   parameter int unsigned INDEX  = 0,
   parameter int unsigned SLOT_W = 6,
   parameter int unsigned NW     = 7
) (
   input  logic                                  clock,
   input  logic                                  clear,
   input  logic                                  update,
   input  logic [NW-1:0]                         n_active,
   input  logic signed [swrs_pkg::SAMPLE_W-1:0]  old_value,
   input  logic [SLOT_W-1:0]                     old_slot,
   input  logic signed [swrs_pkg::SAMPLE_W-1:0]  new_value,
   input  logic [SLOT_W-1:0]                     new_slot,
   input  logic signed [swrs_pkg::SAMPLE_W-1:0]  left_value,
   input  logic [SLOT_W-1:0]                     left_slot,
   input  swrs_pkg::cell_flag_type               left_flag,
   input  logic signed [swrs_pkg::SAMPLE_W-1:0]  right_value,
   input  logic [SLOT_W-1:0]                     right_slot,
   input  swrs_pkg::cell_flag_type               right_flag,
   output logic signed [swrs_pkg::SAMPLE_W-1:0]  cell_value,
   output logic [SLOT_W-1:0]                     cell_slot,
   output swrs_pkg::cell_flag_type               cell_flag
);

   localparam logic [NW:0]       IDX      = (NW + 1)'(INDEX);
   localparam logic [NW:0]       IDX_NEXT = (NW + 1)'(INDEX + 1);
   localparam logic [SLOT_W-1:0] HOME     = SLOT_W'(INDEX);

   logic signed [swrs_pkg::SAMPLE_W-1:0] value_ff, value_in;
   logic [SLOT_W-1:0]                    slot_ff, slot_in;
   logic                                 active, next_active;

   // compacted list after eviction: entry at this rank and the one below it
   logic                                 r_exists, r_lt;
   logic signed [swrs_pkg::SAMPLE_W-1:0] r_value, m_value;
   logic [SLOT_W-1:0]                    r_slot, m_slot;
   logic                                 m_lt;

   assign active      = IDX < {1'b0, n_active};
   assign next_active = IDX_NEXT < {1'b0, n_active};

   // key order: signed value, then slot
   assign cell_flag.lt_old = (value_ff < old_value) ||
                             ((value_ff == old_value) && (slot_ff < old_slot));
   assign cell_flag.lt_new = (value_ff < new_value) ||
                             ((value_ff == new_value) && (slot_ff < new_slot));

   always_comb begin
      r_exists = 1'b1;
      r_value  = value_ff;
      r_slot   = slot_ff;
      r_lt     = cell_flag.lt_new;
      if (!cell_flag.lt_old) begin
         r_value = right_value;
         r_slot  = right_slot;
         r_lt    = right_flag.lt_new;
         r_exists = next_active;
      end

      m_value = value_ff;
      m_slot  = slot_ff;
      m_lt    = cell_flag.lt_new;
      if (INDEX == 0) begin
         m_lt = 1'b1;
      end else if (left_flag.lt_old) begin
         m_value = left_value;
         m_slot  = left_slot;
         m_lt    = left_flag.lt_new;
      end

      priority if (r_exists && r_lt) begin
         value_in = r_value;
         slot_in  = r_slot;
      end else if (m_lt) begin
         value_in = new_value;
         slot_in  = new_slot;
      end else begin
         value_in = m_value;
         slot_in  = m_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         value_ff <= '0;
         slot_ff  <= HOME;
      end else if (update && active) begin
         value_ff <= value_in;
         slot_ff  <= slot_in;
      end
   end

   assign cell_value = value_ff;
   assign cell_slot  = slot_ff;

endmodule

[sv/sliding_window_rank_sorter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_rank_sorter
// Sliding window of samples kept in age order and in ascending rank order.
// ---------------------------------------------------------------------------
// Usage:
//  req channel (valid/ready) carries op, sample, position. op add writes the
//  sample over the oldest slot; op rank returns the position-th smallest;
//  op age returns the position-th oldest; op 3 is dropped with no effect.
//  rsp channel (valid/ready) carries value and bad_position, one transfer per
//  read and none per add. A position at or beyond the active window size
//  returns value zero with bad_position set.
//  csr_we/csr_wdata set window_size (clamped to 1..WINDOW_DEPTH) and clear
//  the window; write only while the block is idle.
// Timing: an item is taken in ST_IDLE and worked in ST_EXEC; no new item is
//  taken until the last is worked. ST_EXEC is needed for the registered read of
//  the sample RAM, which supplies the evicted sample to the rank cell row. A read
//  result is loaded into the output register from ST_EXEC once it is free.
// Stall: the output register holds a result until taken; the next item is
//  still accepted, and a read waits in its work cycle for the slot to free.
// Reset: window_size goes to 64, samples read as zero (a wrap flag and the
//  write slot mark which slots hold data), rank cells go to identity.
//  No clearing pass is needed.
// ---------------------------------------------------------------------------
module sliding_window_rank_sorter #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  swrs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output swrs_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [swrs_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int unsigned NW     = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SW     = swrs_pkg::SAMPLE_W;
   localparam int unsigned PW     = swrs_pkg::POS_W;
   // width for comparing window_size against the depth
   localparam int unsigned CMPW   = (NW > swrs_pkg::CSR_W) ? NW : swrs_pkg::CSR_W;
   // width for position arithmetic (slot + position, compare with n)
   localparam int unsigned CW     = ((SLOT_W > PW) ? SLOT_W : PW) + 1;
   localparam logic [CMPW-1:0] DEPTH_C = CMPW'(WINDOW_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // configuration and window pointer
   logic [swrs_pkg::CSR_W-1:0] window_size_ff;
   logic [SLOT_W-1:0]          write_slot_ff, write_slot_in;
   logic                       wrapped_ff;

   // active window size, clamped
   logic [CMPW-1:0] ws_ext, n_ext;
   logic [NW-1:0]   n_active;

   // captured item
   logic [1:0]            op_ff;
   logic signed [SW-1:0]  sample_ff;
   logic [PW-1:0]         pos_ff;
   logic                  bad_ff;
   logic                  rd_valid_ff;

   // request decode
   logic                  req_fire;
   logic [CW-1:0]         pos_cw, n_cw, age_sum, age_wrap;
   logic [SLOT_W-1:0]     age_slot, rd_addr;
   logic                  pos_bad;

   // sample RAM
   logic                  ram_wr, ram_rd;
   logic [SW-1:0]         ram_q;
   logic signed [SW-1:0]  old_value;

   // rank cell row
   logic signed [SW-1:0]    cell_value [WINDOW_DEPTH];
   logic [SLOT_W-1:0]       cell_slot  [WINDOW_DEPTH];
   swrs_pkg::cell_flag_type cell_flag  [WINDOW_DEPTH];
   logic                    cell_clear, cell_update;
   logic [SLOT_W+PW-1:0]    pos_wide;
   logic [SLOT_W-1:0]       rank_idx;

   // write slot advance
   logic [SLOT_W:0]       slot_inc;
   logic                  slot_wrap;

   // response register
   logic                  rsp_valid_ff;
   swrs_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                  rsp_free, rsp_load;
   logic                  exec_add, exec_read;

   // ---------------- clamped window size ----------------
   assign ws_ext = CMPW'(window_size_ff);
   always_comb begin
      priority if (ws_ext == '0) begin
         n_ext = CMPW'(1);
      end else if (ws_ext > DEPTH_C) begin
         n_ext = DEPTH_C;
      end else begin
         n_ext = ws_ext;
      end
   end
   assign n_active = n_ext[NW-1:0];

   // ---------------- request side ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign pos_cw  = CW'(req_data.position);
   assign n_cw    = CW'(n_active);
   assign pos_bad = pos_cw >= n_cw;

   // age slot = (write_slot + position) mod n; both terms are below n for a valid position
   assign age_sum  = CW'(write_slot_ff) + pos_cw;
   assign age_wrap = (age_sum >= n_cw) ? (age_sum - n_cw) : age_sum;
   assign age_slot = age_wrap[SLOT_W-1:0];

   assign rd_addr = (req_data.op == swrs_pkg::OP_ADD) ? write_slot_ff : age_slot;
   assign ram_rd  = req_fire && ((req_data.op == swrs_pkg::OP_ADD) ||
                                 (req_data.op == swrs_pkg::OP_AGE));

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_data.op;
         sample_ff <= req_data.sample;
         pos_ff    <= req_data.position;
         bad_ff    <= pos_bad;
      end
      // slots fill in order from zero after a clear, so a slot holds data
      // once the window has wrapped or the write slot has passed it
      if (ram_rd) begin
         rd_valid_ff <= wrapped_ff || (rd_addr < write_slot_ff);
      end
   end

   // ---------------- control ----------------
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign exec_add  = (state_ff == ST_EXEC) && (op_ff == swrs_pkg::OP_ADD);
   assign exec_read = (state_ff == ST_EXEC) && (op_ff != swrs_pkg::OP_ADD);
   assign rsp_load  = exec_read && rsp_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.op != swrs_pkg::OP_NONE)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_add || rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- window state ----------------
   assign slot_inc      = {1'b0, write_slot_ff} + (SLOT_W + 1)'(1);
   assign slot_wrap     = (slot_inc == (SLOT_W + 1)'(n_active));
   assign write_slot_in = slot_wrap ? '0 : slot_inc[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= swrs_pkg::WINDOW_SIZE_RESET;
         write_slot_ff  <= '0;
         wrapped_ff     <= 1'b0;
      end else if (csr_we) begin
         window_size_ff <= csr_wdata;
         write_slot_ff  <= '0;
         wrapped_ff     <= 1'b0;
      end else if (exec_add) begin
         write_slot_ff <= write_slot_in;
         if (slot_wrap) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   assign ram_wr = exec_add;

   swrs_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW_DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (write_slot_ff),
      .wr_data (sample_ff),
      .rd_en   (ram_rd),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign old_value = rd_valid_ff ? $signed(ram_q) : '0;

   // ---------------- rank cell row ----------------
   // Each cell knows whether its key sorts before the evicted and the new key;
   // with its neighbors' flags that is enough to shift and insert in one step.
   assign cell_clear  = reset || csr_we;
   assign cell_update = exec_add;

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic signed [SW-1:0]    lv, rv;
      logic [SLOT_W-1:0]       ls, rs;
      swrs_pkg::cell_flag_type lf, rf;

      if (i == 0) begin : g_left_edge
         assign lv = '0;
         assign ls = '0;
         assign lf = '0;
      end else begin : g_left
         assign lv = cell_value[i-1];
         assign ls = cell_slot[i-1];
         assign lf = cell_flag[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_right_edge
         assign rv = '0;
         assign rs = '0;
         assign rf = '0;
      end else begin : g_right
         assign rv = cell_value[i+1];
         assign rs = cell_slot[i+1];
         assign rf = cell_flag[i+1];
      end

      swrs_cell #(
         .INDEX  (i),
         .SLOT_W (SLOT_W),
         .NW     (NW)
      ) u_cell (
         .clock       (clock),
         .clear       (cell_clear),
         .update      (cell_update),
         .n_active    (n_active),
         .old_value   (old_value),
         .old_slot    (write_slot_ff),
         .new_value   (sample_ff),
         .new_slot    (write_slot_ff),
         .left_value  (lv),
         .left_slot   (ls),
         .left_flag   (lf),
         .right_value (rv),
         .right_slot  (rs),
         .right_flag  (rf),
         .cell_value  (cell_value[i]),
         .cell_slot   (cell_slot[i]),
         .cell_flag   (cell_flag[i])
      );
   end

   // rank read picks the cell at the requested rank
   assign pos_wide = {{SLOT_W{1'b0}}, pos_ff};
   assign rank_idx = pos_wide[SLOT_W-1:0];

   // ---------------- response ----------------
   always_comb begin
      rsp_data_in.bad_position = bad_ff;
      priority if (bad_ff) begin
         rsp_data_in.value = '0;
      end else if (op_ff == swrs_pkg::OP_RANK) begin
         rsp_data_in.value = cell_value[rank_idx];
      end else begin
         rsp_data_in.value = old_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sliding window rank sorter bench
// Random and directed add, rank and age transfers at several window sizes.
// Each result is checked against an in-bench window with its own rank order.
// ---------------------------------------------------------------------------
module tb;

   localparam int unsigned DEPTH      = 64;
   localparam int unsigned ITEMS_EACH = 160;   // random items per window size
   localparam int unsigned LONG_HOLD  = 400;   // receiver hold-off, cycles
   localparam int unsigned SETTLE     = 8;     // cycles for a trailing add

   logic                                  clock     = 1'b0;
   logic                                  reset     = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   swrs_pkg::req_type                     req_data  = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   swrs_pkg::rsp_type                     rsp_data;
   logic                                  csr_we    = 1'b0;
   logic [swrs_pkg::CSR_W-1:0]            csr_wdata = '0;

   // handshake seen at the last rising edge, read by the falling-edge drivers
   logic                req_done  = 1'b0;
   logic                rsp_done  = 1'b0;

   swrs_pkg::req_type   req_backlog[$];  // items waiting to be offered
   swrs_pkg::rsp_type   values_due[$];   // read results not yet seen

   int unsigned         fault_count = 0;
   int unsigned         long_hold_asked = 0;

   // window kept by the bench
   logic signed [swrs_pkg::SAMPLE_W-1:0] win_value [DEPTH];
   logic [swrs_pkg::POS_W-1:0]           win_order [DEPTH];  // rank -> slot
   int unsigned                next_slot;          // newest write goes here; also oldest
   logic [swrs_pkg::CSR_W-1:0]           win_size;

   sliding_window_rank_sorter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // window predictor
   // ------------------------------------------------------------------------

   // register value clamped into 1..DEPTH
   function automatic int unsigned live_size();
      if (win_size < 1) return 1;
      if (win_size > DEPTH) return DEPTH;
      return win_size;
   endfunction

   task automatic clear_window();
      for (int unsigned i = 0; i < DEPTH; i++) begin
         win_value[i] = '0;
         win_order[i] = swrs_pkg::POS_W'(i);
      end
      next_slot = 0;
   endtask

   // signed compare, ties go to the lower slot
   function automatic bit sorts_first(int unsigned a, int unsigned b);
      if (win_value[a] != win_value[b]) return win_value[a] < win_value[b];
      return a < b;
   endfunction

   // insertion sort over the live part of the rank order
   task automatic rerank(int unsigned n);
      int unsigned j;
      logic [swrs_pkg::POS_W-1:0] t;
      for (int unsigned i = 1; i < n; i++) begin
         j = i;
         while (j > 0 && sorts_first(win_order[j], win_order[j-1])) begin
            t              = win_order[j];
            win_order[j]   = win_order[j-1];
            win_order[j-1] = t;
            j--;
         end
      end
   endtask

   task automatic apply_request(swrs_pkg::req_type r);
      swrs_pkg::rsp_type want;
      int unsigned n;
      int unsigned slot;
      n = live_size();
      if (next_slot >= n) next_slot = 0;
      case (r.op)
         swrs_pkg::OP_ADD: begin
            win_value[next_slot] = r.sample;
            next_slot++;
            if (next_slot >= n) next_slot = 0;
            rerank(n);
         end
         swrs_pkg::OP_RANK, swrs_pkg::OP_AGE: begin
            if (r.position >= n) begin
               want.value        = '0;
               want.bad_position = 1'b1;
            end else begin
               if (r.op == swrs_pkg::OP_RANK) slot = win_order[r.position];
               else slot = (next_slot + r.position) % n;
               want.value        = win_value[slot];
               want.bad_position = 1'b0;
            end
            values_due.push_back(want);
         end
         default: ;   // unused op: dropped, no result
      endcase
   endtask

   // ------------------------------------------------------------------------
   // monitor: predicts on every request transfer, checks every result transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      swrs_pkg::rsp_type want;
      req_done <= req_valid && req_ready && !reset;
      rsp_done <= rsp_valid && rsp_ready && !reset;
      if (reset) begin
         win_size = swrs_pkg::WINDOW_SIZE_RESET;
         clear_window();
      end else begin
         if (csr_we) begin
            win_size = csr_wdata;
            clear_window();
         end
         if (req_valid && req_ready) apply_request(req_data);
         if (rsp_valid && rsp_ready) begin
            if (values_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: result with none expected: value %h bad %b",
                           $realtime, rsp_data.value, rsp_data.bad_position);
            end else begin
               want = values_due.pop_front();
               if (rsp_data.value !== want.value ||
                   rsp_data.bad_position !== want.bad_position) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("%0t: mismatch: value %h/%h bad %b/%b (exp/act)",
                              $realtime, want.value, rsp_data.value,
                              want.bad_position, rsp_data.bad_position);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request driver: one item from the backlog at a time, random gap after
   // each transfer; runs of zero gap come from the steady flag
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : sender
      int unsigned send_gap;
      bit          send_steady;
      bit          busy;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         busy = req_valid && !req_done;
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data  <= req_backlog.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
               send_gap = send_steady ? 0 : $urandom_range(0, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // result receiver: random stall after each transfer, plus a long hold-off
   // on request so the block backs up and drops req_ready
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      int unsigned hold_left;
      int unsigned long_hold_served;
      bit          take_steady;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (long_hold_served != long_hold_asked) begin
            long_hold_served++;
            hold_left = LONG_HOLD;
         end else if (rsp_done) begin
            if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
            hold_left = take_steady ? 0 : $urandom_range(0, 16);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic queue_item(logic [1:0] op, logic [swrs_pkg::SAMPLE_W-1:0] sample,
                             logic [swrs_pkg::POS_W-1:0] position);
      swrs_pkg::req_type r;
      r.op       = op;
      r.sample   = sample;
      r.position = position;
      req_backlog.push_back(r);
   endtask

   // mix of adds, reads and unused ops; samples lean toward ties and extremes
   task automatic queue_random(int unsigned n, int unsigned count);
      logic [1:0]                    op;
      logic [swrs_pkg::SAMPLE_W-1:0] sample;
      logic [swrs_pkg::POS_W-1:0]    position;
      int unsigned                   pick;
      for (int unsigned k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      op = swrs_pkg::OP_ADD;
         else if (pick < 70) op = swrs_pkg::OP_RANK;
         else if (pick < 95) op = swrs_pkg::OP_AGE;
         else                op = swrs_pkg::OP_NONE;
         case ($urandom_range(0, 3))
            0: sample = swrs_pkg::SAMPLE_W'($urandom_range(0, 6)) - 32'd3;
            1: case ($urandom_range(0, 3))
                  0: sample = 32'h8000_0000;
                  1: sample = 32'h7FFF_FFFF;
                  2: sample = 32'h0000_0000;
                  default: sample = 32'hFFFF_FFFF;
               endcase
            default: sample = $urandom;
         endcase
         if ($urandom_range(0, 3) != 0)
            position = swrs_pkg::POS_W'($urandom_range(0, n - 1));
         else
            position = swrs_pkg::POS_W'($urandom_range(0, DEPTH - 1));
         queue_item(op, sample, position);
      end
   endtask

   // everything offered, taken and answered, then a settle wait for a last add
   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || values_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_window_size(logic [swrs_pkg::CSR_W-1:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      logic [swrs_pkg::CSR_W-1:0] sizes[11];
      int unsigned                n;
      sizes = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd65, 7'd3, 7'd17, 7'd33,
                7'd63, 7'd100};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window, all zeros: reads at both ends, then extremes and a tie
      queue_item(swrs_pkg::OP_RANK, 32'd0, 6'd0);
      queue_item(swrs_pkg::OP_RANK, 32'd0, 6'd63);
      queue_item(swrs_pkg::OP_AGE,  32'd0, 6'd0);
      queue_item(swrs_pkg::OP_AGE,  32'd0, 6'd63);
      queue_item(swrs_pkg::OP_ADD,  32'h7FFF_FFFF, 6'd0);
      queue_item(swrs_pkg::OP_ADD,  32'h8000_0000, 6'd63);
      queue_item(swrs_pkg::OP_ADD,  32'h0000_0000, 6'd0);
      queue_item(swrs_pkg::OP_ADD,  32'hFFFF_FFFF, 6'd0);
      queue_item(swrs_pkg::OP_ADD,  32'h0000_0001, 6'd0);
      queue_item(swrs_pkg::OP_ADD,  32'h0005_0000, 6'd0);
      queue_item(swrs_pkg::OP_ADD,  32'h0005_0000, 6'd0);
      queue_item(swrs_pkg::OP_RANK, 32'd0, 6'd0);
      queue_item(swrs_pkg::OP_RANK, 32'd0, 6'd63);
      queue_item(swrs_pkg::OP_RANK, 32'd0, 6'd1);
      queue_item(swrs_pkg::OP_RANK, 32'd0, 6'd62);
      queue_item(swrs_pkg::OP_AGE,  32'd0, 6'd0);
      queue_item(swrs_pkg::OP_AGE,  32'd0, 6'd63);
      queue_item(swrs_pkg::OP_AGE,  32'd0, 6'd57);
      queue_item(swrs_pkg::OP_NONE, 32'hFFFF_FFFF, 6'd63);
      queue_item(swrs_pkg::OP_RANK, 32'd0, 6'd61);
      long_hold_asked++;
      queue_random(DEPTH, ITEMS_EACH);
      wait_idle();

      for (int unsigned p = 0; p < 11; p++) begin
         write_window_size(sizes[p]);
         if (sizes[p] < 1) n = 1;
         else if (sizes[p] > DEPTH) n = DEPTH;
         else n = sizes[p];
         // past the end of a small window
         if (n < DEPTH) begin
            queue_item(swrs_pkg::OP_RANK, 32'd0, swrs_pkg::POS_W'(n));
            queue_item(swrs_pkg::OP_AGE,  32'd0, 6'd63);
         end
         if (p == 5) long_hold_asked++;
         queue_random(n, ITEMS_EACH);
         wait_idle();
      end

      if (fault_count == 0 && values_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin : watchdog
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
